// ===== rtl/zsce_pkg.sv =====
// ----------------------------------------------------------------------------
// zsce_pkg
// Shared types and constants of the zoomed sprite chunk expander.
// ----------------------------------------------------------------------------
package zsce_pkg;

    localparam int MAP_ADDR_W = 18;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // request kinds on the input channel
    localparam logic REQ_MAP_WRITE = 1'b0;
    localparam logic REQ_SPRITE    = 1'b1;

    localparam logic [15:0] SKIP_CODE  = 16'hffff;
    localparam logic [9:0]  WRAP_LIMIT = 10'h140;
    localparam logic [9:0]  WRAP_SUB   = 10'h200;

    localparam logic [15:0] CODE_MASK_RST = 16'hffff;
    localparam logic [3:0]  Y_OFFSET_RST  = 4'd3;
    localparam logic [7:0]  PRIMASK0_RST  = 8'hf0;
    localparam logic [7:0]  PRIMASK1_RST  = 8'hfc;

    typedef enum logic [1:0] {
        REG_CODE_MASK     = 2'd0,
        REG_Y_OFFSET      = 2'd1,
        REG_PRIMASK_PRIO0 = 2'd2,
        REG_PRIMASK_PRIO1 = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;      // latch sprite entry, start address reduction
        logic map_wr;    // store a chunk-map word
        logic mod_step;  // one step of the address remainder
        logic walk;      // issue chunk reads
        logic flush;     // release the held chunk as the last one
    } t_cmd;

    typedef struct packed {
        logic tile_zero;
        logic mod_last;
        logic walk_done;
        logic pend_vld;
    } t_status;

endpackage

// ===== rtl/zsce_ram.sv =====
// ----------------------------------------------------------------------------
// zsce_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module zsce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/zsce_ctrl.sv =====
// ----------------------------------------------------------------------------
// zsce_ctrl
// Sequencer: accepts requests, then steps address reduction, chunk walk and
// final flush of a sprite entry.
// ----------------------------------------------------------------------------
module zsce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    output logic              o_in_stall,
    input  zsce_pkg::t_status i_status,
    output zsce_pkg::t_cmd    o_cmd
);
    import zsce_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (accept) begin
                    if (i_req_type == REQ_MAP_WRITE) begin
                        o_cmd.map_wr = 1'b1;
                    end else if (!i_status.tile_zero) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (!i_status.pend_vld) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/zsce_dpath.sv =====
// ----------------------------------------------------------------------------
// zsce_dpath
// Datapath: sprite decode, base address remainder, chunk address and
// geometry, chunk map RAM, hold stage for the last flag, output register.
// ----------------------------------------------------------------------------
module zsce_dpath #(
    parameter int MAP_WORDS = 262144
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  zsce_pkg::t_cmd                      i_cmd,
    output zsce_pkg::t_status                   o_status,
    input  logic [zsce_pkg::MAP_ADDR_W-1:0]     i_map_addr,
    input  logic [15:0]                         i_map_data,
    input  logic [15:0]                         i_attr_word0,
    input  logic [15:0]                         i_attr_word1,
    input  logic [15:0]                         i_attr_word2,
    input  logic [15:0]                         i_attr_word3,
    input  logic [15:0]                         i_code_mask,
    input  logic [3:0]                          i_y_offset,
    input  logic [7:0]                          i_primask_prio0,
    input  logic [7:0]                          i_primask_prio1,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [15:0]                         o_tile_code,
    output logic [7:0]                          o_palette,
    output logic                                o_flip_x,
    output logic                                o_flip_y,
    output logic signed [9:0]                   o_pos_x,
    output logic signed [9:0]                   o_pos_y,
    output logic [5:0]                          o_width,
    output logic [4:0]                          o_height,
    output logic [7:0]                          o_primask,
    output logic                                o_last
);
    import zsce_pkg::*;

    localparam int AW        = $clog2(MAP_WORDS);
    localparam int REM_W     = MAP_ADDR_W + 1;
    // base is below 2^18: enough halving steps that MAP_WORDS << steps exceeds it
    localparam int RATIO     = ((1 << MAP_ADDR_W) + MAP_WORDS - 1) / MAP_WORDS;
    localparam int RATIO_LOG = $clog2(RATIO);
    localparam int MOD_STEPS = (RATIO_LOG > 0) ? RATIO_LOG : 1;
    localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // sprite registers
    logic [7:0]  r_pal;
    logic        r_fx;
    logic        r_fy;
    logic [7:0]  r_pm;
    logic [9:0]  r_x;
    logic [9:0]  r_y;
    logic [7:0]  r_zx;
    logic [7:0]  r_zy;

    // remainder unit
    logic [MAP_ADDR_W-1:0] r_rem;
    logic [REM_W-1:0]      r_div;
    logic [STEP_W-1:0]     r_step;

    // chunk walk and read stage
    logic [5:0]  r_chunk;
    logic        r_rd_vld;
    logic [9:0]  r_rd_posx;
    logic [9:0]  r_rd_posy;
    logic [5:0]  r_rd_w;
    logic [4:0]  r_rd_h;

    // held chunk
    logic        r_pend_vld;
    logic [15:0] r_pend_code;
    logic [9:0]  r_pend_posx;
    logic [9:0]  r_pend_posy;
    logic [5:0]  r_pend_w;
    logic [4:0]  r_pend_h;

    // output register
    logic        r_out_vld;
    logic [15:0] r_out_code;
    logic [7:0]  r_out_pal;
    logic        r_out_fx;
    logic        r_out_fy;
    logic [9:0]  r_out_posx;
    logic [9:0]  r_out_posy;
    logic [5:0]  r_out_w;
    logic [4:0]  r_out_h;
    logic [7:0]  r_out_pm;
    logic        r_out_last;

    logic [9:0]  x_raw;
    logic [9:0]  y_raw;
    logic        rem_ge;
    logic [1:0]  k;
    logic [2:0]  j;
    logic [1:0]  px;
    logic [2:0]  py;
    logic [AW:0] addr_sum;
    logic [AW-1:0] rd_addr;
    logic [9:0]  kx0;
    logic [9:0]  kx1;
    logic [10:0] jy0;
    logic [10:0] jy1;
    logic [7:0]  ox0;
    logic [7:0]  ox1;
    logic [7:0]  oy0;
    logic [7:0]  oy1;
    logic [15:0] ram_rdata;
    logic [15:0] code;
    logic        skip;
    logic        out_free;
    logic        drain;
    logic        advance;
    logic        issue;
    logic        pend_to_out;
    logic        map_wr_ok;

    // ---------------- decode ----------------
    assign x_raw = {1'b0, i_attr_word1[8:0]};
    assign y_raw = 10'(i_attr_word0[8:0]) + 10'(i_y_offset);

    // ---------------- remainder ----------------
    assign rem_ge = ({1'b0, r_rem} >= r_div);

    // ---------------- chunk address and geometry ----------------
    assign k  = r_chunk[1:0];
    assign j  = r_chunk[4:2];
    assign px = r_fx ? ~k : k;
    assign py = r_fy ? ~j : j;

    assign addr_sum = (AW+1)'(r_rem[AW-1:0]) + (AW+1)'({py, px});
    assign rd_addr  = (addr_sum >= (AW+1)'(MAP_WORDS))
                    ? AW'(addr_sum - (AW+1)'(MAP_WORDS)) : addr_sum[AW-1:0];

    assign kx0 = 10'(k) * 10'(r_zx);
    assign kx1 = (10'(k) + 10'd1) * 10'(r_zx);
    assign jy0 = 11'(j) * 11'(r_zy);
    assign jy1 = (11'(j) + 11'd1) * 11'(r_zy);
    assign ox0 = kx0[9:2];
    assign ox1 = kx1[9:2];
    assign oy0 = jy0[10:3];
    assign oy1 = jy1[10:3];

    // ---------------- flow control ----------------
    assign code        = ram_rdata & i_code_mask;
    assign skip        = (code == SKIP_CODE);
    assign out_free    = !r_out_vld || !i_out_stall;
    assign drain       = r_rd_vld && (skip || !r_pend_vld || out_free);
    assign advance     = !r_rd_vld || drain;
    assign issue       = i_cmd.walk && !r_chunk[5] && advance;
    assign pend_to_out = r_pend_vld && out_free &&
                         ((r_rd_vld && !skip) || i_cmd.flush);

    assign map_wr_ok = i_cmd.map_wr && ({1'b0, i_map_addr} < REM_W'(MAP_WORDS));

    zsce_ram #(
        .WIDTH(16),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (map_wr_ok),
        .i_waddr(i_map_addr[AW-1:0]),
        .i_wdata(i_map_data),
        .i_re   (issue),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk    <= '0;
            r_step     <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_chunk <= '0;
                r_step  <= STEP_W'(MOD_STEPS - 1);
            end else begin
                if (issue) begin
                    r_chunk <= r_chunk + 6'd1;
                end
                if (i_cmd.mod_step) begin
                    r_step <= r_step - STEP_W'(1);
                end
            end

            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (drain) begin
                r_rd_vld <= 1'b0;
            end

            if (drain && !skip) begin
                r_pend_vld <= 1'b1;
            end else if (pend_to_out) begin
                r_pend_vld <= 1'b0;
            end

            if (pend_to_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pal <= i_attr_word2[15:8];
            r_fx  <= i_attr_word1[14];
            r_fy  <= i_attr_word3[15];
            r_pm  <= i_attr_word1[15] ? i_primask_prio1 : i_primask_prio0;
            r_x   <= (x_raw > WRAP_LIMIT) ? x_raw - WRAP_SUB : x_raw;
            r_y   <= (y_raw > WRAP_LIMIT) ? y_raw - WRAP_SUB : y_raw;
            r_zx  <= 8'(i_attr_word2[6:0]) + 8'd1;
            r_zy  <= 8'(i_attr_word0[15:9]) + 8'd1;
            r_rem <= {i_attr_word3[12:0], 5'b0};
            r_div <= REM_W'(MAP_WORDS) << (MOD_STEPS - 1);
        end else if (i_cmd.mod_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_div[MAP_ADDR_W-1:0];
            end
            r_div <= r_div >> 1;
        end

        if (issue) begin
            r_rd_posx <= r_x + 10'(ox0);
            r_rd_posy <= r_y + 10'(oy0);
            r_rd_w    <= 6'(ox1 - ox0);
            r_rd_h    <= 5'(oy1 - oy0);
        end

        if (drain && !skip) begin
            r_pend_code <= code;
            r_pend_posx <= r_rd_posx;
            r_pend_posy <= r_rd_posy;
            r_pend_w    <= r_rd_w;
            r_pend_h    <= r_rd_h;
        end

        if (pend_to_out) begin
            r_out_code <= r_pend_code;
            r_out_pal  <= r_pal;
            r_out_fx   <= r_fx;
            r_out_fy   <= r_fy;
            r_out_posx <= r_pend_posx;
            r_out_posy <= r_pend_posy;
            r_out_w    <= r_pend_w;
            r_out_h    <= r_pend_h;
            r_out_pm   <= r_pm;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_status.tile_zero = (i_attr_word3[12:0] == 13'd0);
    assign o_status.mod_last  = (r_step == '0);
    assign o_status.walk_done = r_chunk[5] && !r_rd_vld;
    assign o_status.pend_vld  = r_pend_vld;

    assign o_out_valid = r_out_vld;
    assign o_tile_code = r_out_code;
    assign o_palette   = r_out_pal;
    assign o_flip_x    = r_out_fx;
    assign o_flip_y    = r_out_fy;
    assign o_pos_x     = $signed(r_out_posx);
    assign o_pos_y     = $signed(r_out_posy);
    assign o_width     = r_out_w;
    assign o_height    = r_out_h;
    assign o_primask   = r_out_pm;
    assign o_last      = r_out_last;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_stall |-> !pend_to_out)
        else $error("output register overwritten while stalled");

    a_flush_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> !r_rd_vld && r_chunk[5])
        else $error("last chunk released while reads still in flight");

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> ({1'b0, r_rem} < REM_W'(MAP_WORDS)))
        else $error("base address not reduced below map size");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_w <= 6'd32) && (r_out_h <= 5'd16))
        else $error("chunk size out of range");
`endif

endmodule

// ===== rtl/zoomed_sprite_chunk_expander_core.sv =====
// ----------------------------------------------------------------------------
// zoomed_sprite_chunk_expander_core
// Expands sprite attribute entries into up to 32 zoomed map chunks; stores
// chunk-map words; APB register port for mask, Y offset and priority masks.
// ----------------------------------------------------------------------------
// With no skipped chunk and no stall, after the remainder steps (MOD_STEPS is one at
// the default map size) a sprite's first chunk goes through the map read register and
// the hold stage to the output register. A map write or tile-zero entry is done in idle.
// A sprite entry runs the remainder steps on the base address, 32 chunk reads at one per
// cycle unless the output stalls, a read stage drain, the last chunk release, then idle.
// Reset clears the control state and loads register defaults; the map is not cleared.
module zoomed_sprite_chunk_expander_core #(
    parameter int MAP_WORDS = 262144
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [zsce_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [zsce_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [zsce_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [zsce_pkg::MAP_ADDR_W-1:0] i_map_addr,
    input  logic [15:0]                     i_map_data,
    input  logic [15:0]                     i_attr_word0,
    input  logic [15:0]                     i_attr_word1,
    input  logic [15:0]                     i_attr_word2,
    input  logic [15:0]                     i_attr_word3,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [15:0]                     o_tile_code,
    output logic [7:0]                      o_palette,
    output logic                            o_flip_x,
    output logic                            o_flip_y,
    output logic signed [9:0]               o_pos_x,
    output logic signed [9:0]               o_pos_y,
    output logic [5:0]                      o_width,
    output logic [4:0]                      o_height,
    output logic [7:0]                      o_primask,
    output logic                            o_last
);
    import zsce_pkg::*;

    logic [15:0] r_code_mask;
    logic [3:0]  r_y_offset;
    logic [7:0]  r_primask0;
    logic [7:0]  r_primask1;
    logic        cfg_wr;
    t_reg_idx    reg_idx;
    t_cmd        cmd;
    t_status     status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_mask <= CODE_MASK_RST;
            r_y_offset  <= Y_OFFSET_RST;
            r_primask0  <= PRIMASK0_RST;
            r_primask1  <= PRIMASK1_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_CODE_MASK:     r_code_mask <= pwdata[15:0];
                REG_Y_OFFSET:      r_y_offset  <= pwdata[3:0];
                REG_PRIMASK_PRIO0: r_primask0  <= pwdata[7:0];
                REG_PRIMASK_PRIO1: r_primask1  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CODE_MASK:     prdata = CFG_DATA_W'(r_code_mask);
            REG_Y_OFFSET:      prdata = CFG_DATA_W'(r_y_offset);
            REG_PRIMASK_PRIO0: prdata = CFG_DATA_W'(r_primask0);
            REG_PRIMASK_PRIO1: prdata = CFG_DATA_W'(r_primask1);
            default:           prdata = '0;
        endcase
    end

    zsce_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_req_type(i_req_type),
        .o_in_stall(o_in_stall),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    zsce_dpath #(
        .MAP_WORDS(MAP_WORDS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_map_addr     (i_map_addr),
        .i_map_data     (i_map_data),
        .i_attr_word0   (i_attr_word0),
        .i_attr_word1   (i_attr_word1),
        .i_attr_word2   (i_attr_word2),
        .i_attr_word3   (i_attr_word3),
        .i_code_mask    (r_code_mask),
        .i_y_offset     (r_y_offset),
        .i_primask_prio0(r_primask0),
        .i_primask_prio1(r_primask1),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_tile_code    (o_tile_code),
        .o_palette      (o_palette),
        .o_flip_x       (o_flip_x),
        .o_flip_y       (o_flip_y),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_width        (o_width),
        .o_height       (o_height),
        .o_primask      (o_primask),
        .o_last         (o_last)
    );

endmodule

// ===== test/zoomed_sprite_chunk_expander_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zoomed_sprite_chunk_expander_core_test
// Self-checking bench: loads chunk-map tiles, sends sprite entries and map
// writes through the valid/stall input channel, and compares every chunk on
// the output channel with a bit-exact predictor. The run covers several
// register settings and sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module zoomed_sprite_chunk_expander_core_test;
    import zsce_pkg::*;

    localparam int MAP_WORDS   = 262144;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE      = 100;    // more than one full sprite walk
    localparam int PHASE_ITEMS = 38;
    localparam int PRINT_CAP   = 40;

    localparam logic [12:0] TILE_LOW   = 13'h0001;
    localparam logic [12:0] TILE_HIGH  = 13'h1fff;
    localparam logic [12:0] TILE_ODD   = 13'h0aaa;
    localparam logic [12:0] TILE_EVEN  = 13'h1555;
    localparam logic [12:0] TILE_BLANK = 13'h0100;

    typedef struct packed {
        logic [15:0] tile_code;
        logic [7:0]  palette;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [5:0]  width;
        logic [4:0]  height;
        logic [7:0]  primask;
        logic        last;
    } t_chunk;

    typedef struct packed {
        logic        req_type;
        logic [17:0] map_addr;
        logic [15:0] map_data;
        logic [15:0] attr_word0;
        logic [15:0] attr_word1;
        logic [15:0] attr_word2;
        logic [15:0] attr_word3;
    } t_request;

    class chunk_scoreboard;
        bit [15:0] map_words [MAP_WORDS];
        bit [15:0] code_mask = CODE_MASK_RST;
        bit [3:0]  y_offset  = Y_OFFSET_RST;
        bit [7:0]  primask0  = PRIMASK0_RST;
        bit [7:0]  primask1  = PRIMASK1_RST;
        t_chunk    expected_chunks[$];
        int        errors;

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_CODE_MASK:     code_mask = value[15:0];
                REG_Y_OFFSET:      y_offset  = value[3:0];
                REG_PRIMASK_PRIO0: primask0  = value[7:0];
                REG_PRIMASK_PRIO1: primask1  = value[7:0];
                default: ;
            endcase
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
        endfunction

        function void cmp(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                flag(what, want, got);
        endfunction

        // Expands one accepted transfer into the chunks it must produce.
        function void note_input(t_request r);
            int        tile, zx, zy, x, y, i, k, j, col, row;
            int        ox0, ox1, oy0, oy1;
            bit [15:0] code;
            t_chunk    c;
            t_chunk    held;
            bit        have_held;
            if (r.req_type == REQ_MAP_WRITE) begin
                map_words[r.map_addr] = r.map_data;
                return;
            end
            tile = r.attr_word3[12:0];
            if (tile == 0)
                return;
            zy = r.attr_word0[15:9] + 1;
            zx = r.attr_word2[6:0] + 1;
            y  = r.attr_word0[8:0] + y_offset;
            x  = r.attr_word1[8:0];
            if (x > int'(WRAP_LIMIT)) x -= int'(WRAP_SUB);
            if (y > int'(WRAP_LIMIT)) y -= int'(WRAP_SUB);
            have_held = 1'b0;
            for (i = 0; i < 32; i++) begin
                k    = i % 4;
                j    = i / 4;
                col  = r.attr_word1[14] ? 3 - k : k;
                row  = r.attr_word3[15] ? 7 - j : j;
                code = map_words[((tile << 5) + col + (row << 2)) % MAP_WORDS] & code_mask;
                if (code == SKIP_CODE)
                    continue;
                ox0 = (k * zx) / 4;
                ox1 = ((k + 1) * zx) / 4;
                oy0 = (j * zy) / 8;
                oy1 = ((j + 1) * zy) / 8;
                c.tile_code = code;
                c.palette   = r.attr_word2[15:8];
                c.flip_x    = r.attr_word1[14];
                c.flip_y    = r.attr_word3[15];
                c.pos_x     = 10'(x + ox0);
                c.pos_y     = 10'(y + oy0);
                c.width     = 6'(ox1 - ox0);
                c.height    = 5'(oy1 - oy0);
                c.primask   = r.attr_word1[15] ? primask1 : primask0;
                c.last      = 1'b0;
                // hold one back so the final chunk can be marked last
                if (have_held)
                    expected_chunks.push_back(held);
                held      = c;
                have_held = 1'b1;
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_chunks.push_back(held);
            end
        endfunction

        function void check_chunk(t_chunk got);
            t_chunk want;
            if (expected_chunks.size() == 0) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t ns: chunk with nothing expected, tile_code 0x%0h",
                             $time, got.tile_code);
                return;
            end
            want = expected_chunks.pop_front();
            cmp("tile_code", want.tile_code, got.tile_code);
            cmp("palette",   want.palette,   got.palette);
            cmp("flip_x",    want.flip_x,    got.flip_x);
            cmp("flip_y",    want.flip_y,    got.flip_y);
            cmp("pos_x",     want.pos_x,     got.pos_x);
            cmp("pos_y",     want.pos_y,     got.pos_y);
            cmp("width",     want.width,     got.width);
            cmp("height",    want.height,    got.height);
            cmp("primask",   want.primask,   got.primask);
            cmp("last",      want.last,      got.last);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_req_type;
    logic [MAP_ADDR_W-1:0] i_map_addr;
    logic [15:0]           i_map_data;
    logic [15:0]           i_attr_word0;
    logic [15:0]           i_attr_word1;
    logic [15:0]           i_attr_word2;
    logic [15:0]           i_attr_word3;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [15:0]           o_tile_code;
    logic [7:0]            o_palette;
    logic                  o_flip_x;
    logic                  o_flip_y;
    logic signed [9:0]     o_pos_x;
    logic signed [9:0]     o_pos_y;
    logic [5:0]            o_width;
    logic [4:0]            o_height;
    logic [7:0]            o_primask;
    logic                  o_last;

    chunk_scoreboard sb = new();
    int unsigned     send_idle_pct;
    int unsigned     stall_pct;
    int unsigned     cycle_count;
    logic [12:0]     ready_tiles[$];

    zoomed_sprite_chunk_expander_core #(
        .MAP_WORDS(MAP_WORDS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_map_addr   (i_map_addr),
        .i_map_data   (i_map_data),
        .i_attr_word0 (i_attr_word0),
        .i_attr_word1 (i_attr_word1),
        .i_attr_word2 (i_attr_word2),
        .i_attr_word3 (i_attr_word3),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tile_code  (o_tile_code),
        .o_palette    (o_palette),
        .o_flip_x     (o_flip_x),
        .o_flip_y     (o_flip_y),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_width      (o_width),
        .o_height     (o_height),
        .o_primask    (o_primask),
        .o_last       (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output side: check accepted chunks, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_chunk(t_chunk'({o_tile_code, o_palette, o_flip_x, o_flip_y, o_pos_x,
                                     o_pos_y, o_width, o_height, o_primask, o_last}));
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_request random_req();
        t_request r;
        r.req_type   = REQ_SPRITE;
        r.map_addr   = 18'($urandom);
        r.map_data   = 16'($urandom);
        r.attr_word0 = 16'($urandom);
        r.attr_word1 = 16'($urandom);
        r.attr_word2 = 16'($urandom);
        r.attr_word3 = 16'($urandom);
        return r;
    endfunction

    function automatic t_request map_write_req(logic [17:0] addr, logic [15:0] data);
        t_request r;
        r          = random_req();
        r.req_type = REQ_MAP_WRITE;
        r.map_addr = addr;
        r.map_data = data;
        return r;
    endfunction

    function automatic t_request sprite_req(logic [15:0] w0, logic [15:0] w1,
                                            logic [15:0] w2, logic [15:0] w3);
        t_request r;
        r            = random_req();
        r.req_type   = REQ_SPRITE;
        r.attr_word0 = w0;
        r.attr_word1 = w1;
        r.attr_word2 = w2;
        r.attr_word3 = w3;
        return r;
    endfunction

    // One input transfer; valid stays high when the next item follows at once.
    task automatic send_req(input t_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= r.req_type;
        i_map_addr   <= r.map_addr;
        i_map_data   <= r.map_data;
        i_attr_word0 <= r.attr_word0;
        i_attr_word1 <= r.attr_word1;
        i_attr_word2 <= r.attr_word2;
        i_attr_word3 <= r.attr_word3;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(r);
    endtask

    // Writes all 32 chunk words of a tile so sprites on it never read junk.
    task automatic prep_tile(input logic [12:0] tile, input int unsigned skip_pct);
        for (int c = 0; c < 32; c++)
            send_req(map_write_req({tile, 5'(c)},
                     ($urandom_range(99) < skip_pct) ? SKIP_CODE : 16'($urandom)));
        ready_tiles.push_back(tile);
    endtask

    task automatic apb_xfer(input logic write, input t_reg_idx idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic program_regs(input logic [15:0] mask, input logic [3:0] yoff,
                                input logic [7:0] pm0, input logic [7:0] pm1);
        t_reg_idx    regs[4]  = '{REG_CODE_MASK, REG_Y_OFFSET,
                                  REG_PRIMASK_PRIO0, REG_PRIMASK_PRIO1};
        logic [31:0] vals[4];
        logic [31:0] rd;
        vals = '{32'(mask), 32'(yoff), 32'(pm0), 32'(pm1)};
        for (int i = 0; i < 4; i++) begin
            apb_xfer(1'b1, regs[i], vals[i], rd);
            sb.set_reg(regs[i], vals[i]);
        end
        for (int i = 0; i < 4; i++) begin
            apb_xfer(1'b0, regs[i], '0, rd);
            sb.cmp("register readback", vals[i], rd);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every expected chunk, then cover work that emits nothing.
    task automatic settle();
        while (sb.expected_chunks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic directed_items();
        send_req(sprite_req(16'hffff, 16'hffff, 16'hffff, 16'h6000));   // tile zero
        send_req(sprite_req(16'h0000, 16'h0000, 16'h0000, {3'b000, TILE_LOW}));
        send_req(sprite_req(16'hffff, 16'hc1ff, 16'hff7f, {3'b100, TILE_HIGH}));
        // right at the wrap threshold, then just past it
        send_req(sprite_req(16'h813d, 16'h4140, 16'h5a40, {3'b000, TILE_ODD}));
        send_req(sprite_req(16'h3f3e, 16'h8141, 16'ha51f, {3'b100, TILE_EVEN}));
        send_req(sprite_req(16'h1234, 16'h8020, 16'h7705, {3'b000, TILE_BLANK}));
        // skipped final chunk moves the last marker back
        send_req(map_write_req({TILE_LOW, 5'd31}, SKIP_CODE));
        send_req(sprite_req(16'h0e10, 16'h0010, 16'h3303, {3'b000, TILE_LOW}));
        send_req(map_write_req({TILE_LOW, 5'd0}, 16'h0000));
        send_req(sprite_req(16'h0e10, 16'h4010, 16'h3303, {3'b100, TILE_LOW}));
        for (int i = 0; i < 6; i++)
            send_req(sprite_req(16'($urandom), 16'($urandom), 16'($urandom),
                                {3'($urandom), ready_tiles[$urandom_range(0, 4)]}));
    endtask

    task automatic random_items();
        t_request    r;
        int unsigned sel;
        logic [12:0] tile;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            sel  = $urandom_range(99);
            r    = random_req();
            tile = ready_tiles[$urandom_range(0, ready_tiles.size() - 1)];
            if (sel < 55) begin
                r.attr_word3[12:0] = tile;
                if ($urandom_range(3) == 0)
                    r.attr_word1[8:0] = 9'(9'h13c + $urandom_range(8));
            end else if (sel < 62) begin
                r.attr_word3[12:0] = '0;
            end else if (sel < 90) begin
                r.req_type = REQ_MAP_WRITE;
                r.map_addr = {tile, 5'($urandom_range(31))};
                if ($urandom_range(4) == 0)
                    r.map_data = SKIP_CODE;
            end else begin
                r.req_type = REQ_MAP_WRITE;
            end
            send_req(r);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_req_type    <= REQ_MAP_WRITE;
        i_map_addr    <= '0;
        i_map_data    <= '0;
        i_attr_word0  <= '0;
        i_attr_word1  <= '0;
        i_attr_word2  <= '0;
        i_attr_word3  <= '0;
        i_out_stall   <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values stay in force for the directed part
        prep_tile(TILE_LOW, 15);
        prep_tile(TILE_HIGH, 15);
        prep_tile(TILE_ODD, 15);
        prep_tile(TILE_EVEN, 15);
        prep_tile(TILE_BLANK, 100);
        directed_items();
        i_in_valid <= 1'b0;
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    program_regs(16'hffff, 4'd0, 8'h00, 8'hff);
                end
                1: begin
                    send_idle_pct = 79;
                    stall_pct     = 0;
                    program_regs(16'h0000, 4'd15, 8'hff, 8'h00);
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 79;
                    program_regs(16'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
                end
                default: begin
                    send_idle_pct = 38;
                    stall_pct     = 38;
                    program_regs(16'hffff, 4'($urandom), 8'($urandom), 8'($urandom));
                end
            endcase
            random_items();
            i_in_valid <= 1'b0;
            settle();
        end

        if (sb.expected_chunks.size() != 0) begin
            sb.errors++;
            $display("%0t ns: %0d expected chunks never arrived",
                     $time, sb.expected_chunks.size());
        end
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== zoomed_sprite_chunk_expander_core.f =====
rtl/zsce_pkg.sv
rtl/zsce_ram.sv
rtl/zsce_ctrl.sv
rtl/zsce_dpath.sv
rtl/zoomed_sprite_chunk_expander_core.sv
test/zoomed_sprite_chunk_expander_core_test.sv
